// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/hbwc_pkg.sv =====
`default_nettype none

package hbwc_pkg;

   // vector length and field widths
   localparam int VEC_BITS = 64;
   localparam int CENTRE_W = 64;
   localparam int RADIUS_W = 7;
   localparam int WEIGHT_W = 7;
   localparam int COUNT_W  = 61;

   // popcount and loop index widths
   localparam int CNT_W = $clog2(VEC_BITS + 1);
   localparam int IDX_W = CNT_W + 1;
   localparam int SUM_W = IDX_W + 1;

   // popcount runs one byte per step
   localparam int NBYTES = (VEC_BITS + 7) / 8;
   localparam int BCNT_W = (NBYTES > 1) ? $clog2(NBYTES) : 1;
   localparam int PAD_W  = NBYTES * 8;

   // binomial table C(n,k), n and k from 0 to VEC_BITS, row-major
   localparam int BINOM_W   = COUNT_W;
   localparam int ROW_LEN   = VEC_BITS + 1;
   localparam int TBL_DEPTH = ROW_LEN * ROW_LEN;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   // 61x61 products are formed from 32x32 partial products
   localparam int HALF_W = 32;
   localparam int HI_W   = BINOM_W - HALF_W;

   // largest count any query can return: C(64,32)
   localparam logic [COUNT_W-1:0] MAX_COUNT = 61'd1832624140942590534;

   // sequencer steps
   localparam int UPC_W = 3;
   typedef logic [UPC_W-1:0] upc_type;
   localparam upc_type UPC_IDLE = 3'd0;
   localparam upc_type UPC_POP  = 3'd1;
   localparam upc_type UPC_INIT = 3'd2;
   localparam upc_type UPC_RD   = 3'd3;
   localparam upc_type UPC_MUL0 = 3'd4;
   localparam upc_type UPC_MUL1 = 3'd5;
   localparam upc_type UPC_MUL2 = 3'd6;
   localparam upc_type UPC_DONE = 3'd7;

   typedef enum logic [2:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_NO_START,
      JC_POP_MORE,
      JC_TERM_END,
      JC_OUT_BUSY
   } jcond_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD_LO,
      ACC_ADD_HI
   } acc_op_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LL,
      MUL_HL,
      MUL_LH
   } mul_op_type;

   typedef struct packed {
      jcond_type  jcond;
      upc_type    target;
      acc_op_type acc_op;
      mul_op_type mul_op;
      logic       ld_req;
      logic       pop;
      logic       init_loop;
      logic       latch_ops;
      logic       step_kj;
      logic       ld_out;
   } ctrl_word_type;

   // control store: one word per step; a false jump condition falls through
   // to the next step, and the last step wraps back to idle
   function automatic ctrl_word_type ucode_rom(input upc_type upc);
      ctrl_word_type cw;
      cw.jcond     = JC_NEVER;
      cw.target    = UPC_IDLE;
      cw.acc_op    = ACC_HOLD;
      cw.mul_op    = MUL_NONE;
      cw.ld_req    = 1'b0;
      cw.pop       = 1'b0;
      cw.init_loop = 1'b0;
      cw.latch_ops = 1'b0;
      cw.step_kj   = 1'b0;
      cw.ld_out    = 1'b0;
      case (upc)
         UPC_IDLE: begin
            cw.ld_req = 1'b1;
            cw.jcond  = JC_NO_START;
            cw.target = UPC_IDLE;
         end
         UPC_POP: begin
            cw.pop    = 1'b1;
            cw.jcond  = JC_POP_MORE;
            cw.target = UPC_POP;
         end
         UPC_INIT: begin
            cw.init_loop = 1'b1;
            cw.acc_op    = ACC_CLEAR;
         end
         UPC_RD: begin
            cw.acc_op = ACC_ADD_HI;
            cw.jcond  = JC_TERM_END;
            cw.target = UPC_DONE;
         end
         UPC_MUL0: begin
            cw.latch_ops = 1'b1;
            cw.mul_op    = MUL_LL;
         end
         UPC_MUL1: begin
            cw.acc_op = ACC_ADD_LO;
            cw.mul_op = MUL_HL;
         end
         UPC_MUL2: begin
            cw.acc_op  = ACC_ADD_HI;
            cw.mul_op  = MUL_LH;
            cw.step_kj = 1'b1;
            cw.jcond   = JC_ALWAYS;
            cw.target  = UPC_RD;
         end
         UPC_DONE: begin
            cw.ld_out = 1'b1;
            cw.jcond  = JC_OUT_BUSY;
            cw.target = UPC_DONE;
         end
         default: begin
            cw.jcond  = JC_ALWAYS;
            cw.target = UPC_IDLE;
         end
      endcase
      return cw;
   endfunction

   function automatic logic [3:0] pop8(input logic [7:0] b);
      logic [3:0] cnt;
      cnt = 4'd0;
      for (int i = 0; i < 8; i++) begin
         cnt = cnt + 4'(b[i]);
      end
      return cnt;
   endfunction

   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [CNT_W-1:0] row,
                                                  input logic [CNT_W-1:0] col);
      return TBL_AW'(row) * TBL_AW'(ROW_LEN) + TBL_AW'(col);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/hamming_ball_weight_count.sv =====
`default_nettype none

// Counts the 64-bit words of weight target_weight that lie within Hamming
// distance radius of centre_vector, and returns the count as one rsp word per
// req word. After reset the block first builds a table of all binomials
// C(n,k), n,k = 0..64, in an internal RAM by Pascal's rule, and req_stall
// stays high until this fill ends. A query then loops once over each
// contributing (ones-cleared, zeros-set) pair, at most 33 of them. The
// sequencer returns to its idle step in the same cycle that the result is
// loaded into the rsp register. The loop body (steps RD, MUL0, MUL1, MUL2)
// is set by the single shared 32x32 multiplier, which forms each 61-bit
// product from three partial products. One query is in flight at a time; a
// finished result waits in the rsp register, and the next req word is
// accepted while it waits. Radius above 64 counts as 64, and a target weight
// above 64 gives zero.
module hamming_ball_weight_count (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hbwc_pkg::CENTRE_W-1:0]    req_centre_vector,
   input  logic [hbwc_pkg::RADIUS_W-1:0]    req_radius,
   input  logic [hbwc_pkg::WEIGHT_W-1:0]    req_target_weight,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [hbwc_pkg::COUNT_W-1:0]     rsp_vector_count
);

   localparam int CNT_W   = hbwc_pkg::CNT_W;
   localparam int IDX_W   = hbwc_pkg::IDX_W;
   localparam int SUM_W   = hbwc_pkg::SUM_W;
   localparam int BINOM_W = hbwc_pkg::BINOM_W;
   localparam int HALF_W  = hbwc_pkg::HALF_W;
   localparam int HI_W    = hbwc_pkg::HI_W;
   localparam int COUNT_W = hbwc_pkg::COUNT_W;
   localparam int TBL_AW  = hbwc_pkg::TBL_AW;
   localparam int PAD_W   = hbwc_pkg::PAD_W;
   localparam int BCNT_W  = hbwc_pkg::BCNT_W;
   localparam int VB      = hbwc_pkg::VEC_BITS;

   // ---------------------------------------------------------------------
   // Sequencer: step counter addressing the control store
   // ---------------------------------------------------------------------
   hbwc_pkg::upc_type       upc_ff, upc_in;
   hbwc_pkg::ctrl_word_type cw;
   logic                    cond_true;
   logic                    accept;
   logic                    out_busy;
   logic                    term_end;
   logic                    pop_more;

   // ---------------------------------------------------------------------
   // Table fill: issue stage reads row n-1, write stage writes row n
   // ---------------------------------------------------------------------
   logic               fill_run_ff, fill_run_in;
   logic               fill_done_ff, fill_done_in;
   logic [CNT_W-1:0]   fn_ff, fn_in;
   logic [CNT_W-1:0]   fk_ff, fk_in;
   logic               fw_valid_ff, fw_valid_in;
   logic [CNT_W-1:0]   fw_n_ff, fw_n_in;
   logic [CNT_W-1:0]   fw_k_ff, fw_k_in;
   logic [BINOM_W-1:0] fprev_ff, fprev_in;
   logic               fill_last_issue;
   logic               fill_last_write;

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   logic [PAD_W-1:0]    cv_ff, cv_in;
   logic [BCNT_W-1:0]   bcnt_ff, bcnt_in;
   logic [CNT_W-1:0]    s_ff, s_in;
   logic [CNT_W-1:0]    m_ff, m_in;
   logic [CNT_W-1:0]    r_ff, r_in;
   logic [IDX_W-1:0]    w_ff, w_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [BINOM_W-1:0]  opa_ff, opa_in;
   logic [BINOM_W-1:0]  opb_ff, opb_in;
   logic [2*HALF_W-1:0] prod_ff, prod_in;
   logic [COUNT_W-1:0]  acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [HALF_W-1:0]   mul_a, mul_b;
   logic [2*HALF_W-1:0] product;
   logic [IDX_W-1:0]    s_ext;

   // table RAM ports
   logic               tbl_wr_en;
   logic [TBL_AW-1:0]  tbl_wr_addr;
   logic [BINOM_W-1:0] tbl_wr_data;
   logic [TBL_AW-1:0]  tbl_addr_a, tbl_addr_b;
   logic [BINOM_W-1:0] tbl_rd_a, tbl_rd_b;

   // take a query only from the idle step, and only once the table is built
   assign req_stall = !(fill_done_ff && (upc_ff == hbwc_pkg::UPC_IDLE));
   assign accept    = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign s_ext     = IDX_W'(s_ff);

   // the pair loop ends once ones-cleared passes s, zeros-set passes 64-s,
   // or the distance k+j passes the radius; all three only grow with k,j
   assign term_end = (k_ff > s_ext) || (j_ff > IDX_W'(m_ff)) ||
                     ((SUM_W'(k_ff) + SUM_W'(j_ff)) > SUM_W'(r_ff));
   assign pop_more = (bcnt_ff != BCNT_W'(hbwc_pkg::NBYTES - 1));

   always_comb begin
      cw = hbwc_pkg::ucode_rom(upc_ff);
      case (cw.jcond)
         hbwc_pkg::JC_NEVER:    cond_true = 1'b0;
         hbwc_pkg::JC_ALWAYS:   cond_true = 1'b1;
         hbwc_pkg::JC_NO_START: cond_true = !accept;
         hbwc_pkg::JC_POP_MORE: cond_true = pop_more;
         hbwc_pkg::JC_TERM_END: cond_true = term_end;
         hbwc_pkg::JC_OUT_BUSY: cond_true = out_busy;
         default:               cond_true = 1'b0;
      endcase
      // fall through to the next step; the done step wraps to idle
      upc_in = cond_true ? cw.target : hbwc_pkg::upc_type'(upc_ff + 1'b1);
   end

   // ---------------------------------------------------------------------
   // Table fill control
   // ---------------------------------------------------------------------
   assign fill_last_issue = (fn_ff == CNT_W'(VB)) && (fk_ff == CNT_W'(VB));
   assign fill_last_write = fw_valid_ff && (fw_n_ff == CNT_W'(VB)) &&
                            (fw_k_ff == CNT_W'(VB));

   always_comb begin
      fill_run_in  = fill_run_ff && !fill_last_issue;
      fill_done_in = fill_done_ff || fill_last_write;
      fn_in        = fn_ff;
      fk_in        = fk_ff;
      if (fill_run_ff) begin
         if (fk_ff == CNT_W'(VB)) begin
            fk_in = '0;
            fn_in = CNT_W'(fn_ff + 1'b1);
         end else begin
            fk_in = CNT_W'(fk_ff + 1'b1);
         end
      end
      fw_valid_in = fill_run_ff;
      fw_n_in     = fn_ff;
      fw_k_in     = fk_ff;
      // C(n-1,k) arrives now; hold it as C(n-1,k-1) for the next entry
      fprev_in    = fw_valid_ff ? tbl_rd_a : fprev_ff;

      tbl_wr_en   = fw_valid_ff;
      tbl_wr_addr = hbwc_pkg::tbl_addr(fw_n_ff, fw_k_ff);
      if (fw_n_ff == '0) begin
         tbl_wr_data = (fw_k_ff == '0) ? BINOM_W'(1) : '0;
      end else if (fw_k_ff == '0) begin
         tbl_wr_data = tbl_rd_a;
      end else begin
         tbl_wr_data = fprev_ff + tbl_rd_a;
      end
   end

   // port A serves the fill until it ends, then C(s,k); port B gives C(64-s,j)
   assign tbl_addr_a = fill_done_ff ?
                       hbwc_pkg::tbl_addr(s_ff, k_ff[CNT_W-1:0]) :
                       hbwc_pkg::tbl_addr(CNT_W'(fn_ff - 1'b1), fk_ff);
   assign tbl_addr_b = hbwc_pkg::tbl_addr(m_ff, j_ff[CNT_W-1:0]);

   hbwc_ram #(
      .WIDTH(BINOM_W),
      .DEPTH(hbwc_pkg::TBL_DEPTH)
   ) u_tbl (
      .clock     (clock),
      .wr_en     (tbl_wr_en),
      .wr_addr   (tbl_wr_addr),
      .wr_data   (tbl_wr_data),
      .rd_addr_a (tbl_addr_a),
      .rd_data_a (tbl_rd_a),
      .rd_addr_b (tbl_addr_b),
      .rd_data_b (tbl_rd_b)
   );

   // ---------------------------------------------------------------------
   // Shared multiplier: low x low from fresh RAM data, cross terms from the
   // latched operands. The high x high term only lands above bit 63.
   // ---------------------------------------------------------------------
   always_comb begin
      case (cw.mul_op)
         hbwc_pkg::MUL_LL: begin
            mul_a = tbl_rd_a[HALF_W-1:0];
            mul_b = tbl_rd_b[HALF_W-1:0];
         end
         hbwc_pkg::MUL_HL: begin
            mul_a = HALF_W'(opa_ff[BINOM_W-1:HALF_W]);
            mul_b = opb_ff[HALF_W-1:0];
         end
         hbwc_pkg::MUL_LH: begin
            mul_a = opa_ff[HALF_W-1:0];
            mul_b = HALF_W'(opb_ff[BINOM_W-1:HALF_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      cv_in   = cv_ff;
      bcnt_in = bcnt_ff;
      s_in    = s_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      w_in    = w_ff;
      k_in    = k_ff;
      j_in    = j_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;

      // capture the query; clamp radius to 64 and an unreachable weight to 65
      if (cw.ld_req && accept) begin
         cv_in   = PAD_W'(req_centre_vector[VB-1:0]);
         bcnt_in = '0;
         s_in    = '0;
         r_in    = (req_radius > hbwc_pkg::RADIUS_W'(VB)) ?
                   CNT_W'(VB) : CNT_W'(req_radius);
         w_in    = (req_target_weight > hbwc_pkg::WEIGHT_W'(VB)) ?
                   IDX_W'(VB + 1) : IDX_W'(req_target_weight);
      end

      // popcount one byte per step
      if (cw.pop) begin
         s_in    = CNT_W'(s_ff + CNT_W'(hbwc_pkg::pop8(cv_ff[7:0])));
         cv_in   = cv_ff >> 8;
         bcnt_in = BCNT_W'(bcnt_ff + 1'b1);
      end

      // first pair: k ones cleared and j zeros set with k-j = s-w, both >= 0
      if (cw.init_loop) begin
         m_in = CNT_W'(VB) - s_ff;
         if (w_ff >= s_ext) begin
            k_in = '0;
            j_in = w_ff - s_ext;
         end else begin
            k_in = s_ext - w_ff;
            j_in = '0;
         end
      end

      if (cw.latch_ops) begin
         opa_in = tbl_rd_a;
         opb_in = tbl_rd_b;
      end

      // next distance of the same parity: one more of each
      if (cw.step_kj) begin
         k_in = IDX_W'(k_ff + 1'b1);
         j_in = IDX_W'(j_ff + 1'b1);
      end

      prod_in = (cw.mul_op == hbwc_pkg::MUL_NONE) ? '0 : product;

      // the total fits in 61 bits, so arithmetic mod 2^61 is exact
      case (cw.acc_op)
         hbwc_pkg::ACC_HOLD:   acc_in = acc_ff;
         hbwc_pkg::ACC_CLEAR:  acc_in = '0;
         hbwc_pkg::ACC_ADD_LO: acc_in = acc_ff + prod_ff[COUNT_W-1:0];
         hbwc_pkg::ACC_ADD_HI: acc_in = acc_ff + {prod_ff[HI_W-1:0], HALF_W'(0)};
         default:              acc_in = acc_ff;
      endcase

      // result register: load when free, drop once taken
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (cw.ld_out && !out_busy) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = acc_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= hbwc_pkg::UPC_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_run_ff  <= 1'b1;
         fill_done_ff <= 1'b0;
         fn_ff        <= '0;
         fk_ff        <= '0;
         fw_valid_ff  <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_run_ff  <= fill_run_in;
         fill_done_ff <= fill_done_in;
         fn_ff        <= fn_in;
         fk_ff        <= fk_in;
         fw_valid_ff  <= fw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fw_n_ff      <= fw_n_in;
      fw_k_ff      <= fw_k_in;
      fprev_ff     <= fprev_in;
      cv_ff        <= cv_in;
      bcnt_ff      <= bcnt_in;
      s_ff         <= s_in;
      m_ff         <= m_in;
      r_ff         <= r_in;
      w_ff         <= w_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vector_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/hbwc_ram.sv =====
`default_nettype none

module hbwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/hbwc_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module hbwc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [hbwc_pkg::COUNT_W-1:0] rsp_vector_count
);

   // hold a stalled result word
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_vector_count))

   // one query at a time: an accepted word closes the input side
   `ASSERT_NEXT(a_one_query, clock, reset, req_valid && !req_stall, req_stall)

   // no count exceeds C(64,32)
   `ASSERT_IMPLY(a_count_bound, clock, reset, rsp_valid, rsp_vector_count <= hbwc_pkg::MAX_COUNT)

endmodule

bind hamming_ball_weight_count hbwc_checker u_hbwc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_vector_count (rsp_vector_count)
);

`default_nettype wire

// ===== test/tb_hamming_ball_weight_count.sv =====
`default_nettype none

module tb_hamming_ball_weight_count;

   localparam int CENTRE_W = hbwc_pkg::CENTRE_W;
   localparam int RADIUS_W = hbwc_pkg::RADIUS_W;
   localparam int WEIGHT_W = hbwc_pkg::WEIGHT_W;
   localparam int COUNT_W  = hbwc_pkg::COUNT_W;
   localparam int VEC_BITS = hbwc_pkg::VEC_BITS;
   localparam int BIT_W    = $clog2(CENTRE_W);
   localparam logic [COUNT_W-1:0] MAX_COUNT = hbwc_pkg::MAX_COUNT;

   // Timeout: about 1050 queries, each with its gaps and stalls, plus the table
   // fill after reset and one long hold; LIMIT_CYCLES lies well above their total.
   localparam int LIMIT_CYCLES   = 1_000_000;
   // Let the longest query finish before the final verdict.
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_QUERIES = 1026;
   // Hold the rsp side off for this long once, after a number of results.
   localparam int LONG_HOLD      = 700;
   localparam int HOLD_AFTER     = 150;

   localparam logic [CENTRE_W-1:0] ALL_ONES = {CENTRE_W{1'b1}};

   typedef struct packed {
      logic [CENTRE_W-1:0] centre;
      logic [RADIUS_W-1:0] radius;
      logic [WEIGHT_W-1:0] weight;
      logic                typed;   // count below is known by inspection
      logic [COUNT_W-1:0]  count;
   } query_row_type;

   // Receiver stall patterns, one picked per segment.
   typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_mode_type;

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [CENTRE_W-1:0] req_centre_vector = '0;
   logic [RADIUS_W-1:0] req_radius        = '0;
   logic [WEIGHT_W-1:0] req_target_weight = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [COUNT_W-1:0]  rsp_vector_count;

   // Binomials C(n,k), n and k from 0 to VEC_BITS; zero where k > n.
   logic [63:0]         choose_tbl [0:VEC_BITS][0:VEC_BITS];
   logic [COUNT_W-1:0]  pending_counts [$];
   int                  mismatches = 0;
   int                  rsp_seen   = 0;
   int                  burst_left = 0;

   // Directed queries: corners of every field plus the special cases
   // (radius clamp, weight out of range, radius zero, odd parity skips).
   query_row_type directed_rows [24] = '{
      '{64'h0, 7'd0, 7'd0, 1'b1, 61'd1},              // centre itself, weight 0
      '{64'h0, 7'd0, 7'd1, 1'b1, 61'd0},              // radius zero, wrong weight
      '{ALL_ONES, 7'd0, 7'd64, 1'b1, 61'd1},
      '{ALL_ONES, 7'd0, 7'd63, 1'b1, 61'd0},
      '{64'h0, 7'd64, 7'd32, 1'b1, MAX_COUNT},        // largest possible count
      '{64'h0, 7'd127, 7'd32, 1'b1, MAX_COUNT},       // radius clamps to 64
      '{64'h0, 7'd1, 7'd1, 1'b1, 61'd64},
      '{64'h0, 7'd2, 7'd2, 1'b1, 61'd2016},
      '{64'h0, 7'd64, 7'd0, 1'b1, 61'd1},
      '{64'h0, 7'd64, 7'd64, 1'b1, 61'd1},
      '{64'h0, 7'd64, 7'd65, 1'b1, 61'd0},            // weight above 64
      '{64'h0, 7'd127, 7'd127, 1'b1, 61'd0},
      '{ALL_ONES, 7'd64, 7'd0, 1'b1, 61'd1},
      '{ALL_ONES, 7'd1, 7'd63, 1'b1, 61'd64},
      '{ALL_ONES, 7'd127, 7'd127, 1'b1, 61'd0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 7'd32, 1'b1, MAX_COUNT},
      '{64'h5555_5555_5555_5555, 7'd0, 7'd32, 1'b1, 61'd1},
      '{64'h8000_0000_0000_0000, 7'd1, 7'd0, 1'b1, 61'd1},
      '{64'h0000_0000_0000_00FF, 7'd7, 7'd7, 1'b0, 61'd0},   // even d skipped
      '{64'hFFFF_FFFF_0000_0000, 7'd10, 7'd32, 1'b0, 61'd0},
      '{64'h0123_4567_89AB_CDEF, 7'd20, 7'd30, 1'b0, 61'd0},
      '{64'hDEAD_BEEF_CAFE_F00D, 7'd63, 7'd31, 1'b0, 61'd0},
      '{64'h0000_0000_0000_0001, 7'd64, 7'd33, 1'b0, 61'd0},
      '{64'h7FFF_FFFF_FFFF_FFFF, 7'd65, 7'd2, 1'b0, 61'd0}
   };

   hamming_ball_weight_count dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_centre_vector (req_centre_vector),
      .req_radius        (req_radius),
      .req_target_weight (req_target_weight),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vector_count  (rsp_vector_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Count the weight-w words within the ball: walk distance d, split it into
   // k ones cleared and d-k zeros set, and add the ways to pick each side.
   function automatic logic [COUNT_W-1:0] count_ball_words(
      input logic [CENTRE_W-1:0] centre,
      input logic [RADIUS_W-1:0] radius,
      input logic [WEIGHT_W-1:0] weight
   );
      int ones, reach, d, num, k, lo, hi;
      logic [63:0] total;
      ones  = $countones(centre);
      reach = (radius > VEC_BITS) ? VEC_BITS : int'(radius);
      total = '0;
      for (d = 0; d <= reach; d++) begin
         num = ones + d - int'(weight);
         // skip odd or negative splits: no whole k exists
         if (num < 0 || num[0]) continue;
         k  = num / 2;
         lo = d - (VEC_BITS - ones);
         if (lo < 0) lo = 0;
         hi = (d < ones) ? d : ones;
         if (k < lo || k > hi) continue;
         total += choose_tbl[ones][k] * choose_tbl[VEC_BITS - ones][d - k];
      end
      return total[COUNT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] want,
                                  input logic [COUNT_W-1:0] got);
      $display("MISMATCH at rsp word %0d: %s, expected %0d, got %0d",
               rsp_seen, what, want, got);
      mismatches++;
   endtask

   // Offer one req word and hold it until accepted, then queue its count.
   // Pace the sender in bursts: after each burst, drop valid for a random gap, which may be empty.
   task automatic send_query(input logic [CENTRE_W-1:0] centre,
                             input logic [RADIUS_W-1:0] radius,
                             input logic [WEIGHT_W-1:0] weight,
                             input logic typed, input logic [COUNT_W-1:0] count);
      int gap;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_centre_vector <= centre;
      req_radius        <= radius;
      req_target_weight <= weight;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_counts.push_back(typed ? count : count_ball_words(centre, radius, weight));
      burst_left--;
      if (burst_left <= 0) begin
         // mostly short bursts; now and then a long run with no idling at all
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
   endtask

   initial begin : stimulus
      logic [CENTRE_W-1:0] centre;
      logic [RADIUS_W-1:0] radius;
      logic [WEIGHT_W-1:0] weight;
      int ones, reach, lo, hi;

      // Build Pascal's triangle for the predictor.
      for (int n = 0; n <= VEC_BITS; n++) begin
         for (int k = 0; k <= VEC_BITS; k++) begin
            if (k == 0)
               choose_tbl[n][k] = 64'd1;
            else if (n == 0)
               choose_tbl[n][k] = 64'd0;
            else
               choose_tbl[n][k] = choose_tbl[n-1][k-1] + choose_tbl[n-1][k];
         end
      end

      // Hold reset, then release it; the block then fills its table with req_stall high.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      burst_left = $urandom_range(1, 24);
      foreach (directed_rows[i]) begin
         send_query(directed_rows[i].centre, directed_rows[i].radius,
                    directed_rows[i].weight, directed_rows[i].typed, directed_rows[i].count);
      end

      for (int q = 0; q < RANDOM_QUERIES; q++) begin
         // Spread the popcount: plain random, sparse, dense and near-extreme centres.
         case ($urandom_range(0, 5))
            0, 1: centre = {$urandom, $urandom};
            2: centre = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: centre = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
            4: begin
               centre = '0;
               repeat ($urandom_range(0, 4))
                  centre[BIT_W'($urandom_range(0, CENTRE_W-1))] = 1'b1;
            end
            default: begin
               centre = ALL_ONES;
               repeat ($urandom_range(0, 4))
                  centre[BIT_W'($urandom_range(0, CENTRE_W-1))] = 1'b0;
            end
         endcase
         if ($urandom_range(0, 9) == 0)
            radius = RADIUS_W'($urandom_range(65, 127));
         else
            radius = RADIUS_W'($urandom_range(0, 64));
         // Aim the weight inside the reachable band so most counts are nonzero.
         if ($urandom_range(0, 7) == 0) begin
            weight = WEIGHT_W'($urandom_range(0, 127));
         end else begin
            ones  = $countones(centre);
            reach = (radius > VEC_BITS) ? VEC_BITS : int'(radius);
            lo    = (ones - reach < 0) ? 0 : ones - reach;
            hi    = (ones + reach > VEC_BITS) ? VEC_BITS : ones + reach;
            weight = WEIGHT_W'($urandom_range(lo, hi));
         end
         send_query(centre, radius, weight, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Wait for every count, then allow one more query time for strays.
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: pick a stall pattern per segment. Once, after enough results,
   // hold off for a long stretch so the block backs up and stalls req.
   initial begin : receiver
      stall_mode_type mode;
      int             seg_len, period, duty;
      bit             held;
      held = 1'b0;
      forever begin
         if (!held && rsp_seen >= HOLD_AFTER) begin
            held = 1'b1;
            for (int i = 0; i < LONG_HOLD; i++) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode    = stall_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(16, 160);
         period  = $urandom_range(2, 9);
         duty    = $urandom_range(1, period - 1);
         for (int i = 0; i < seg_len; i++) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_COIN:     rsp_stall <= ($urandom_range(0, 3) < 2);
               STALL_PERIODIC: rsp_stall <= ((i % period) < duty);
               default:        rsp_stall <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Check each accepted rsp word against the oldest pending count.
   always @(posedge clock) begin : check_rsp
      logic [COUNT_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("rsp word with no query pending", '0, rsp_vector_count);
         end else begin
            want = pending_counts.pop_front();
            if (rsp_vector_count !== want)
               report_mismatch("vector_count", want, rsp_vector_count);
         end
         rsp_seen++;
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
